// ----- rtl/adc_pkg.sv -----
package adc_pkg;

    // command codes
    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    // audit kinds
    localparam logic [1:0] AUD_NONE  = 2'd0;
    localparam logic [1:0] AUD_GRANT = 2'd1;
    localparam logic [1:0] AUD_DENY  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] subject_id;
        logic [31:0] target_id;
        logic [15:0] object_class;
        logic [31:0] requested_perms;
        logic [31:0] fill_allowed;
        logic [31:0] fill_decided;
        logic [31:0] fill_audit_allow;
        logic [31:0] fill_audit_deny;
        logic [31:0] fill_new_context;
    } in_beat_t;

    typedef struct packed {
        logic        hit;
        logic        granted;
        logic [1:0]  audit_kind;
        logic [31:0] audited_perms;
        logic [31:0] created_context;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_HEAD_Q,
        ST_FIND,
        ST_CMP,
        ST_TAKE,
        ST_TAKE2,
        ST_EVAL,
        ST_SW_START,
        ST_SW_HEAD,
        ST_SW_RD,
        ST_SW_ACT,
        ST_SW_FREE,
        ST_RESULT
    } state_t;

    // what a chain walk is looking for
    typedef enum logic [1:0] {
        PH_LOOKUP,
        PH_INSERT,
        PH_WIDEN
    } phase_t;

    typedef struct packed {
        logic        granted;
        logic [1:0]  kind;
        logic [31:0] audited;
        logic [31:0] missing;
        logic        widen;
    } eval_t;

    // decision evaluation against an allowed mask
    function automatic eval_t evaluate(input logic [31:0] perms,
                                       input logic [31:0] allowed,
                                       input logic [31:0] aud_allow,
                                       input logic [31:0] aud_deny,
                                       input logic        enforcing);
        eval_t ev;
        logic  lacking;
        ev.missing = perms & ~allowed;
        ev.audited = (ev.missing != 32'd0) ? (ev.missing & aud_deny) : (perms & aud_allow);
        lacking    = (perms == 32'd0) || (ev.missing != 32'd0);
        ev.granted = !(lacking && enforcing);
        ev.widen   = lacking && !enforcing;
        if (ev.audited == 32'd0)
        begin
            ev.kind = AUD_NONE;
        end
        else if (ev.missing != 32'd0)
        begin
            ev.kind = AUD_DENY;
        end
        else
        begin
            ev.kind = AUD_GRANT;
        end
        return ev;
    endfunction

endpackage

// ----- rtl/adc_if.sv -----
interface adc_in_if;
    logic               valid;
    logic               ready;
    adc_pkg::in_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface adc_out_if;
    logic               valid;
    logic               ready;
    adc_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/adc_bucket_unit.sv -----
// Bucket index: hash of the key reduced modulo the bucket count.
// Power-of-two counts take the low bits of the hash directly. Other counts use a reciprocal multiply for the
// quotient, then a subtract on the low bits for the remainder.
module adc_bucket_unit #(
    parameter int BUCKET_COUNT = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [31:0]                     subject_id,
    input  logic [31:0]                     target_id,
    input  logic [15:0]                     object_class,
    output logic                            done,
    output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);

    localparam int         BW   = $clog2(BUCKET_COUNT);
    localparam bit         POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
    // ceil(2^(32+BW) / BUCKET_COUNT): exact floor quotient for any 32-bit hash
    localparam longint unsigned MAGIC_FULL =
        ((64'd1 << (32 + BW)) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
    localparam logic [32:0]   MAGIC = 33'(MAGIC_FULL);
    localparam logic [BW-1:0] BLOW  = BW'(BUCKET_COUNT);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [64:0]   prod_reg, prod_next;
    logic [BW-1:0] low_reg, low_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic [31:0]   key_hash;
    logic [BW-1:0] quot_low;

    assign key_hash = subject_id ^ (target_id << 2) ^ {16'd0, object_class};
    assign quot_low = prod_reg[32 + BW +: BW];

    // multiply on start, remainder on the next cycle; a power-of-two count takes the remainder on start
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        low_next  = low_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            low_next = key_hash[BW-1:0];
            if (POW2)
            begin
                rem_next  = key_hash[BW-1:0];
                done_next = 1'b1;
            end
            else
            begin
                prod_next = {33'd0, key_hash} * {32'd0, MAGIC};
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            // remainder is below the count, so the low bits suffice
            rem_next  = low_reg - BW'(quot_low * BLOW);
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        low_reg  <= low_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

// ----- rtl/access_decision_cache.sv -----
// Channel | Dir | Beat contents
// req     | in  | cmd, key (subject, target, class), requested perms, fill decision
// rsp     | out | hit, granted, audit kind, audited perms, created context
// cfg     | in  | cfg_we / cfg_wdata: enforcing mode, one bit
//
// One request at a time. Bucket index: low hash bits for a power-of-two bucket count,
// else a reciprocal multiply. Chain walk: each node is read through the registered entry
// memory read port, after the bucket head is read through the registered head read port.
// A fill on an empty pool sweeps buckets: hot entries are cleared, cold entries are freed.
// After reset and after a flush a clearing pass over all bucket heads and entries holds
// req.ready low. A finished response waits in the output register while rsp.ready is low.
module access_decision_cache #(
    parameter int BUCKET_COUNT = 512,
    parameter int ENTRY_COUNT  = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    adc_in_if.sink     req,
    adc_out_if.source  rsp
);

    localparam int BW    = $clog2(BUCKET_COUNT);
    localparam int EW    = $clog2(ENTRY_COUNT);
    localparam int PW    = $clog2(ENTRY_COUNT + 1);
    localparam int MAXC  = (BUCKET_COUNT > ENTRY_COUNT) ? BUCKET_COUNT : ENTRY_COUNT;
    localparam int CLW   = $clog2(MAXC);
    localparam int LIMIT = 2 * BUCKET_COUNT + 2;
    localparam int RW    = $clog2(LIMIT + 1);

    localparam logic [PW-1:0]  NIL       = PW'(ENTRY_COUNT);
    localparam logic [PW-1:0]  FREE_TOP  = PW'(ENTRY_COUNT - 1);
    localparam logic [CLW-1:0] CLR_LAST  = CLW'(MAXC - 1);
    localparam logic [BW-1:0]  HAND_LAST = BW'(BUCKET_COUNT - 1);
    localparam logic [RW-1:0]  RND_LIMIT = RW'(LIMIT);

    // memories
    logic [PW-1:0] head_mem  [BUCKET_COUNT];
    logic [63:0]   ids_mem   [ENTRY_COUNT];
    logic [15:0]   cls_mem   [ENTRY_COUNT];
    logic [31:0]   allow_mem [ENTRY_COUNT];
    logic [31:0]   dec_mem   [ENTRY_COUNT];
    logic [31:0]   aa_mem    [ENTRY_COUNT];
    logic [31:0]   ad_mem    [ENTRY_COUNT];
    logic [31:0]   crt_mem   [ENTRY_COUNT];
    logic          hot_mem   [ENTRY_COUNT];
    logic [PW-1:0] link_mem  [ENTRY_COUNT];

    logic [PW-1:0] head_q;
    logic [63:0]   ids_q;
    logic [15:0]   cls_q;
    logic [31:0]   allow_q, dec_q, aa_q, ad_q, crt_q;
    logic          hot_q;
    logic [PW-1:0] link_q;

    // control state
    adc_pkg::state_t    state_reg, state_next;
    adc_pkg::phase_t    phase_reg, phase_next;
    adc_pkg::in_beat_t  req_reg;
    adc_pkg::out_beat_t res_reg, res_next;
    adc_pkg::out_beat_t rsp_data_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               enf_reg;
    logic [CLW-1:0]     clr_reg, clr_next;
    logic [BW-1:0]      bkt_reg, bkt_next;
    logic [BW-1:0]      hand_reg, hand_next;
    logic [PW-1:0]      cur_reg, cur_next;
    logic [PW-1:0]      prev_reg, prev_next;
    logic [PW-1:0]      nxt_reg, nxt_next;
    logic [PW-1:0]      free_reg, free_next;
    logic [RW-1:0]      rnd_reg, rnd_next;

    // memory ports
    logic [BW-1:0]  bkt_raddr;
    logic [EW-1:0]  ent_raddr;
    logic           head_we;
    logic [BW-1:0]  head_waddr;
    logic [PW-1:0]  head_wdata;
    logic           link_we;
    logic [EW-1:0]  link_waddr;
    logic [PW-1:0]  link_wdata;
    logic           hot_we;
    logic [EW-1:0]  hot_waddr;
    logic           hot_wdata;
    logic           data_we;
    logic [EW-1:0]  data_waddr;
    logic           allow_we;
    logic [EW-1:0]  allow_waddr;
    logic [31:0]    allow_wdata;

    logic               accept;
    logic               hash_done;
    logic [BW-1:0]      hash_bkt;
    logic [31:0]        find_mask;
    logic               key_match;
    adc_pkg::eval_t     ev_entry, ev_fill;

    assign accept = req.valid && req.ready;

    adc_bucket_unit #(
        .BUCKET_COUNT(BUCKET_COUNT)
    ) u_bucket (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .subject_id   (req.data.subject_id),
        .target_id    (req.data.target_id),
        .object_class (req.data.object_class),
        .done         (hash_done),
        .bucket       (hash_bkt)
    );

    // enforcing mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enf_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            enf_reg <= cfg_wdata;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req.data;
        end
    end

    // read addresses
    assign bkt_raddr = (state_reg == adc_pkg::ST_SW_START) ? hand_reg : bkt_reg;
    assign ent_raddr = (state_reg == adc_pkg::ST_TAKE) ? free_reg[EW-1:0] : cur_reg[EW-1:0];

    // what the walk compares
    always_comb
    begin
        case (phase_reg)
            adc_pkg::PH_INSERT: find_mask = req_reg.fill_decided;
            adc_pkg::PH_WIDEN:  find_mask = req_reg.requested_perms;
            default:
            begin
                if (req_reg.cmd == adc_pkg::CMD_QUERY)
                begin
                    find_mask = 32'd0;
                end
                else
                begin
                    find_mask = req_reg.requested_perms;
                end
            end
        endcase
    end

    assign key_match = (ids_q == {req_reg.subject_id, req_reg.target_id})
                    && (cls_q == req_reg.object_class)
                    && ((find_mask & dec_q) == find_mask);

    assign ev_entry = adc_pkg::evaluate(req_reg.requested_perms, allow_q, aa_q, ad_q, enf_reg);
    assign ev_fill  = adc_pkg::evaluate(req_reg.requested_perms, req_reg.fill_allowed,
                                        req_reg.fill_audit_allow, req_reg.fill_audit_deny,
                                        enf_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        clr_next       = clr_reg;
        bkt_next       = bkt_reg;
        hand_next      = hand_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        free_next      = free_reg;
        rnd_next       = rnd_reg;
        head_we        = 1'b0;
        head_waddr     = bkt_reg;
        head_wdata     = NIL;
        link_we        = 1'b0;
        link_waddr     = cur_reg[EW-1:0];
        link_wdata     = NIL;
        hot_we         = 1'b0;
        hot_waddr      = cur_reg[EW-1:0];
        hot_wdata      = 1'b0;
        data_we        = 1'b0;
        data_waddr     = free_reg[EW-1:0];
        allow_we       = 1'b0;
        allow_waddr    = cur_reg[EW-1:0];
        allow_wdata    = allow_q | ev_entry.missing;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            adc_pkg::ST_CLEAR:
            begin
                head_waddr = clr_reg[BW-1:0];
                head_we    = ({1'b0, clr_reg} < (CLW + 1)'(BUCKET_COUNT));
                link_waddr = clr_reg[EW-1:0];
                link_we    = ({1'b0, clr_reg} < (CLW + 1)'(ENTRY_COUNT));
                link_wdata = (clr_reg == '0) ? NIL : PW'(clr_reg - 1'b1);
                hot_waddr  = clr_reg[EW-1:0];
                hot_we     = link_we;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = adc_pkg::ST_IDLE;
                end
            end

            adc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (req.data.cmd == adc_pkg::CMD_FLUSH)
                    begin
                        state_next = adc_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = adc_pkg::ST_HASH;
                        phase_next = (req.data.cmd == adc_pkg::CMD_FILL) ?
                                     adc_pkg::PH_INSERT : adc_pkg::PH_LOOKUP;
                    end
                end
            end

            adc_pkg::ST_HASH:
            begin
                if (hash_done)
                begin
                    bkt_next   = hash_bkt;
                    state_next = adc_pkg::ST_HEAD;
                end
            end

            adc_pkg::ST_HEAD:
            begin
                state_next = adc_pkg::ST_HEAD_Q;
            end

            adc_pkg::ST_HEAD_Q:
            begin
                cur_next   = head_q;
                state_next = adc_pkg::ST_FIND;
            end

            // end of chain or fetch the node
            adc_pkg::ST_FIND:
            begin
                if (cur_reg == NIL)
                begin
                    case (phase_reg)
                        adc_pkg::PH_INSERT:
                        begin
                            if (free_reg == NIL)
                            begin
                                rnd_next   = '0;
                                state_next = adc_pkg::ST_SW_START;
                            end
                            else
                            begin
                                state_next = adc_pkg::ST_TAKE;
                            end
                        end
                        default: state_next = adc_pkg::ST_RESULT;
                    endcase
                end
                else
                begin
                    state_next = adc_pkg::ST_CMP;
                end
            end

            adc_pkg::ST_CMP:
            begin
                if (key_match)
                begin
                    case (phase_reg)
                        adc_pkg::PH_INSERT:
                        begin
                            state_next = adc_pkg::ST_EVAL;
                        end
                        adc_pkg::PH_WIDEN:
                        begin
                            allow_we    = 1'b1;
                            allow_wdata = allow_q | ev_fill.missing;
                            state_next  = adc_pkg::ST_RESULT;
                        end
                        default:
                        begin
                            res_next.hit             = 1'b1;
                            res_next.created_context = crt_q;
                            if (req_reg.cmd == adc_pkg::CMD_CHECK)
                            begin
                                res_next.granted       = ev_entry.granted;
                                res_next.audit_kind    = ev_entry.kind;
                                res_next.audited_perms = ev_entry.audited;
                                allow_we               = ev_entry.widen;
                            end
                            state_next = adc_pkg::ST_RESULT;
                        end
                    endcase
                end
                else
                begin
                    cur_next   = link_q;
                    state_next = adc_pkg::ST_FIND;
                end
            end

            adc_pkg::ST_TAKE:
            begin
                state_next = adc_pkg::ST_TAKE2;
            end

            // link the new entry at the chain head
            adc_pkg::ST_TAKE2:
            begin
                data_we     = 1'b1;
                allow_we    = 1'b1;
                allow_waddr = free_reg[EW-1:0];
                allow_wdata = req_reg.fill_allowed;
                hot_we      = 1'b1;
                hot_waddr   = free_reg[EW-1:0];
                hot_wdata   = 1'b1;
                link_we     = 1'b1;
                link_waddr  = free_reg[EW-1:0];
                link_wdata  = head_q;
                head_we     = 1'b1;
                head_wdata  = free_reg;
                free_next   = link_q;
                state_next  = adc_pkg::ST_EVAL;
            end

            adc_pkg::ST_EVAL:
            begin
                res_next.hit             = 1'b0;
                res_next.granted         = ev_fill.granted;
                res_next.audit_kind      = ev_fill.kind;
                res_next.audited_perms   = ev_fill.audited;
                res_next.created_context = req_reg.fill_new_context;
                if (ev_fill.widen)
                begin
                    phase_next = adc_pkg::PH_WIDEN;
                    state_next = adc_pkg::ST_HEAD;
                end
                else
                begin
                    state_next = adc_pkg::ST_RESULT;
                end
            end

            // clock sweep over buckets
            adc_pkg::ST_SW_START:
            begin
                if (free_reg != NIL)
                begin
                    state_next = adc_pkg::ST_TAKE;
                end
                else if (rnd_reg == RND_LIMIT)
                begin
                    state_next = adc_pkg::ST_EVAL;
                end
                else
                begin
                    prev_next  = NIL;
                    state_next = adc_pkg::ST_SW_HEAD;
                end
            end

            adc_pkg::ST_SW_HEAD:
            begin
                cur_next   = head_q;
                state_next = adc_pkg::ST_SW_RD;
            end

            adc_pkg::ST_SW_RD:
            begin
                if (cur_reg == NIL)
                begin
                    hand_next  = (hand_reg == HAND_LAST) ? '0 : hand_reg + 1'b1;
                    rnd_next   = rnd_reg + 1'b1;
                    state_next = adc_pkg::ST_SW_START;
                end
                else
                begin
                    state_next = adc_pkg::ST_SW_ACT;
                end
            end

            adc_pkg::ST_SW_ACT:
            begin
                if (hot_q)
                begin
                    hot_we     = 1'b1;
                    prev_next  = cur_reg;
                    cur_next   = link_q;
                    state_next = adc_pkg::ST_SW_RD;
                end
                else
                begin
                    nxt_next = link_q;
                    if (prev_reg == NIL)
                    begin
                        head_we    = 1'b1;
                        head_waddr = hand_reg;
                        head_wdata = link_q;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[EW-1:0];
                        link_wdata = link_q;
                    end
                    state_next = adc_pkg::ST_SW_FREE;
                end
            end

            // push the cold entry on the free list
            adc_pkg::ST_SW_FREE:
            begin
                link_we    = 1'b1;
                link_wdata = free_reg;
                free_next  = cur_reg;
                cur_next   = nxt_reg;
                state_next = adc_pkg::ST_SW_RD;
            end

            adc_pkg::ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (req_reg.cmd == adc_pkg::CMD_FLUSH)
                    begin
                        clr_next   = '0;
                        free_next  = FREE_TOP;
                        hand_next  = '0;
                        state_next = adc_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = adc_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = adc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adc_pkg::ST_CLEAR;
            phase_reg     <= adc_pkg::PH_LOOKUP;
            rsp_valid_reg <= 1'b0;
            clr_reg       <= '0;
            hand_reg      <= '0;
            free_reg      <= FREE_TOP;
            rnd_reg       <= '0;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
            clr_reg       <= clr_next;
            hand_reg      <= hand_next;
            free_reg      <= free_next;
            rnd_reg       <= rnd_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        bkt_reg <= bkt_next;
        nxt_reg <= nxt_next;
        if (state_reg == adc_pkg::ST_RESULT && (!rsp_valid_reg || rsp.ready))
        begin
            rsp_data_reg <= res_reg;
        end
    end

    // bucket head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[bkt_raddr];
    end

    // link and hot memories
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (hot_we)
        begin
            hot_mem[hot_waddr] <= hot_wdata;
        end
        link_q <= link_mem[ent_raddr];
        hot_q  <= hot_mem[ent_raddr];
    end

    // entry data memories
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            ids_mem[data_waddr] <= {req_reg.subject_id, req_reg.target_id};
            cls_mem[data_waddr] <= req_reg.object_class;
            dec_mem[data_waddr] <= req_reg.fill_decided;
            aa_mem[data_waddr]  <= req_reg.fill_audit_allow;
            ad_mem[data_waddr]  <= req_reg.fill_audit_deny;
            crt_mem[data_waddr] <= req_reg.fill_new_context;
        end
        if (allow_we)
        begin
            allow_mem[allow_waddr] <= allow_wdata;
        end
        ids_q   <= ids_mem[ent_raddr];
        cls_q   <= cls_mem[ent_raddr];
        dec_q   <= dec_mem[ent_raddr];
        aa_q    <= aa_mem[ent_raddr];
        ad_q    <= ad_mem[ent_raddr];
        crt_q   <= crt_mem[ent_raddr];
        allow_q <= allow_mem[ent_raddr];
    end

    assign req.ready = (state_reg == adc_pkg::ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // checks
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == adc_pkg::ST_CLEAR |-> !req.ready)
        else $error("request taken during clearing pass");

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= NIL)
        else $error("free list head out of range");

    a_flush_path: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.data.cmd == adc_pkg::CMD_FLUSH |=> state_reg == adc_pkg::ST_RESULT)
        else $error("flush did not go to response");

    a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, hand_reg} < (BW + 1)'(BUCKET_COUNT))
        else $error("clock hand out of range");

endmodule
